@@ src/unix_time_to_calendar_date_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for unix_time_to_calendar_date_core
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UNIX_TIME_TO_CALENDAR_DATE_CORE_ASSERT_SVH
`define UNIX_TIME_TO_CALENDAR_DATE_CORE_ASSERT_SVH

// same-cycle implication
`define UTCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/utcd_pkg.sv @@
// ----------------------------------------------------------------------------
// utcd_pkg
// Constants, reciprocals and types shared by the calendar date converter.
// ----------------------------------------------------------------------------
package utcd_pkg;

    localparam int UTCD_NSTG = 8;

    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int EPOCH_SHIFT   = 719468;
    localparam int DAYS_PER_ERA  = 146097;
    localparam int DAYS_ERA_M1   = 146096;
    localparam int DAYS_100Y_M1  = 36524;
    localparam int DAYS_PER_YEAR = 365;

    // days since the start of era four (year 1600), the first era the input reaches
    localparam int DAY_OFS = EPOCH_SHIFT - 4 * DAYS_PER_ERA;

    // reciprocals: floor(x / d) == (x * RCP) >> SHIFT over the operand range used
    localparam logic [25:0] DAY_RCP  = 26'd50903317;  // /675,  x < 2^25, shift 35
    localparam logic [13:0] HR_RCP   = 14'd9321;      // /225,  x < 2^13, shift 21
    localparam logic [10:0] MIN_RCP  = 11'd1093;      // /15,   x < 2^10, shift 14
    localparam logic [15:0] Y4_RCP   = 16'd45965;     // /365,  x < 2^16, shift 24
    localparam logic [17:0] YR_RCP   = 18'd183860;    // /365,  x < 2^18, shift 26
    localparam logic [10:0] MON_RCP  = 11'd1714;      // /153,  x < 2^11, shift 18

    localparam logic [11:0] YEAR_ERA4 = 12'd1600;
    localparam logic [11:0] YEAR_ERA5 = 12'd2000;

    typedef struct packed {
        logic [UTCD_NSTG-1:0] en;
        logic [UTCD_NSTG-1:0] vld;
    } t_pipe_ctrl;

    // first day of each March-based month within the March-based year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        begin
            case (mp)
                4'd0:    v = 9'd0;
                4'd1:    v = 9'd31;
                4'd2:    v = 9'd61;
                4'd3:    v = 9'd92;
                4'd4:    v = 9'd122;
                4'd5:    v = 9'd153;
                4'd6:    v = 9'd184;
                4'd7:    v = 9'd214;
                4'd8:    v = 9'd245;
                4'd9:    v = 9'd275;
                4'd10:   v = 9'd306;
                4'd11:   v = 9'd337;
                default: v = 9'd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ src/unix_time_to_calendar_date_core.sv @@
// ----------------------------------------------------------------------------
// unix_time_to_calendar_date_core
// Converts a 32-bit Unix timestamp to Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Eight-stage pipeline: one timestamp is taken every cycle unless back-pressure
// has filled every stage; the stages mostly alternate constant-reciprocal
// multiplies and the subtracts that use their quotients. Back-pressure stalls
// only the stages that are full, so bubbles close up while the output waits.
// No reset pass or configuration is needed; every 32-bit input is a legal timestamp.
`include "unix_time_to_calendar_date_core_assert.svh"

module unix_time_to_calendar_date_core
    import utcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] unix_seconds
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // year, month, day_of_month, hour,
                                          // minute, second, zero pad
);

    t_pipe_ctrl w_ctrl;

    utcd_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_ctrl      (w_ctrl)
    );

    // stage 0: whole days
    logic [50:0] w_day_prod;
    logic [15:0] n_s0_days;
    logic [15:0] r_s0_days;
    logic [31:0] r_s0_t;

    assign w_day_prod = 51'(i_s_axis_tdata[31:7]) * 51'(DAY_RCP);
    assign n_s0_days  = w_day_prod[50:35];

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[0]) begin
            r_s0_days <= n_s0_days;
            r_s0_t    <= i_s_axis_tdata;
        end
    end

    // stage 1: second of day, day of era
    logic [31:0] w_day_secs;
    logic [17:0] w_shifted;
    logic        n_s1_era5;
    logic [16:0] n_s1_sod;
    logic [17:0] n_s1_doe;
    logic [16:0] r_s1_sod;
    logic [17:0] r_s1_doe;
    logic        r_s1_era5;

    assign w_day_secs = 32'(r_s0_days) * 32'(SECS_PER_DAY);
    assign n_s1_sod   = 17'(r_s0_t - w_day_secs);
    assign w_shifted  = 18'(r_s0_days) + 18'(DAY_OFS);
    assign n_s1_era5  = (w_shifted >= 18'(DAYS_PER_ERA));
    assign n_s1_doe   = n_s1_era5 ? 18'(w_shifted - 18'(DAYS_PER_ERA)) : w_shifted;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[1]) begin
            r_s1_sod  <= n_s1_sod;
            r_s1_doe  <= n_s1_doe;
            r_s1_era5 <= n_s1_era5;
        end
    end

    // stage 2: hour, leap-day corrections
    logic [26:0] w_hr_prod;
    logic [31:0] w_q4_prod;
    logic [4:0]  n_s2_hh;
    logic [6:0]  n_s2_q4;
    logic [2:0]  n_s2_q100;
    logic        n_s2_q400;
    logic [16:0] r_s2_sod;
    logic [17:0] r_s2_doe;
    logic        r_s2_era5;
    logic [4:0]  r_s2_hh;
    logic [6:0]  r_s2_q4;
    logic [2:0]  r_s2_q100;
    logic        r_s2_q400;

    assign w_hr_prod = 27'(r_s1_sod[16:4]) * 27'(HR_RCP);
    assign n_s2_hh   = w_hr_prod[25:21];
    assign w_q4_prod = 32'(r_s1_doe[17:2]) * 32'(Y4_RCP);
    assign n_s2_q4   = w_q4_prod[30:24];
    assign n_s2_q100 = 3'(r_s1_doe >= 18'(DAYS_100Y_M1))
                     + 3'(r_s1_doe >= 18'(2 * DAYS_100Y_M1))
                     + 3'(r_s1_doe >= 18'(3 * DAYS_100Y_M1))
                     + 3'(r_s1_doe >= 18'(4 * DAYS_100Y_M1));
    assign n_s2_q400 = (r_s1_doe == 18'(DAYS_ERA_M1));

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[2]) begin
            r_s2_sod  <= r_s1_sod;
            r_s2_doe  <= r_s1_doe;
            r_s2_era5 <= r_s1_era5;
            r_s2_hh   <= n_s2_hh;
            r_s2_q4   <= n_s2_q4;
            r_s2_q100 <= n_s2_q100;
            r_s2_q400 <= n_s2_q400;
        end
    end

    // stage 3: seconds of hour, corrected day count
    logic [11:0] n_s3_remh;
    logic [17:0] n_s3_adj;
    logic [11:0] r_s3_remh;
    logic [17:0] r_s3_adj;
    logic [17:0] r_s3_doe;
    logic        r_s3_era5;
    logic [4:0]  r_s3_hh;

    assign n_s3_remh = 12'(r_s2_sod - 17'(r_s2_hh) * 17'(SECS_PER_HOUR));
    assign n_s3_adj  = 18'(r_s2_doe - 18'(r_s2_q4) + 18'(r_s2_q100) - 18'(r_s2_q400));

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[3]) begin
            r_s3_remh <= n_s3_remh;
            r_s3_adj  <= n_s3_adj;
            r_s3_doe  <= r_s2_doe;
            r_s3_era5 <= r_s2_era5;
            r_s3_hh   <= r_s2_hh;
        end
    end

    // stage 4: minute, year of era
    logic [20:0] w_min_prod;
    logic [35:0] w_yr_prod;
    logic [5:0]  n_s4_mi;
    logic [8:0]  n_s4_yoe;
    logic [11:0] r_s4_remh;
    logic [5:0]  r_s4_mi;
    logic [8:0]  r_s4_yoe;
    logic [17:0] r_s4_doe;
    logic        r_s4_era5;
    logic [4:0]  r_s4_hh;

    assign w_min_prod = 21'(r_s3_remh[11:2]) * 21'(MIN_RCP);
    assign n_s4_mi    = w_min_prod[19:14];
    assign w_yr_prod  = 36'(r_s3_adj) * 36'(YR_RCP);
    assign n_s4_yoe   = w_yr_prod[34:26];

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[4]) begin
            r_s4_remh <= r_s3_remh;
            r_s4_mi   <= n_s4_mi;
            r_s4_yoe  <= n_s4_yoe;
            r_s4_doe  <= r_s3_doe;
            r_s4_era5 <= r_s3_era5;
            r_s4_hh   <= r_s3_hh;
        end
    end

    // stage 5: second, day of March-based year
    logic [1:0]  w_y100;
    logic [18:0] w_year_days;
    logic [5:0]  n_s5_ss;
    logic [8:0]  n_s5_doy;
    logic [5:0]  r_s5_ss;
    logic [8:0]  r_s5_doy;
    logic [8:0]  r_s5_yoe;
    logic        r_s5_era5;
    logic [4:0]  r_s5_hh;
    logic [5:0]  r_s5_mi;

    assign w_y100      = 2'(r_s4_yoe >= 9'd100) + 2'(r_s4_yoe >= 9'd200)
                       + 2'(r_s4_yoe >= 9'd300);
    assign w_year_days = 19'(r_s4_yoe) * 19'(DAYS_PER_YEAR) + 19'(r_s4_yoe[8:2])
                       - 19'(w_y100);
    assign n_s5_ss     = 6'(r_s4_remh - 12'(r_s4_mi) * 12'(SECS_PER_MIN));
    assign n_s5_doy    = 9'(19'(r_s4_doe) - w_year_days);

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[5]) begin
            r_s5_ss   <= n_s5_ss;
            r_s5_doy  <= n_s5_doy;
            r_s5_yoe  <= r_s4_yoe;
            r_s5_era5 <= r_s4_era5;
            r_s5_hh   <= r_s4_hh;
            r_s5_mi   <= r_s4_mi;
        end
    end

    // stage 6: March-based month
    logic [10:0] w_mp_num;
    logic [21:0] w_mp_prod;
    logic [3:0]  n_s6_mp;
    logic [3:0]  r_s6_mp;
    logic [8:0]  r_s6_doy;
    logic [8:0]  r_s6_yoe;
    logic        r_s6_era5;
    logic [4:0]  r_s6_hh;
    logic [5:0]  r_s6_mi;
    logic [5:0]  r_s6_ss;

    assign w_mp_num  = 11'(r_s5_doy) * 11'd5 + 11'd2;
    assign w_mp_prod = 22'(w_mp_num) * 22'(MON_RCP);
    assign n_s6_mp   = w_mp_prod[21:18];

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[6]) begin
            r_s6_mp   <= n_s6_mp;
            r_s6_doy  <= r_s5_doy;
            r_s6_yoe  <= r_s5_yoe;
            r_s6_era5 <= r_s5_era5;
            r_s6_hh   <= r_s5_hh;
            r_s6_mi   <= r_s5_mi;
            r_s6_ss   <= r_s5_ss;
        end
    end

    // stage 7: calendar fields, output register
    logic        w_next_year;
    logic [11:0] n_s7_year;
    logic [3:0]  n_s7_month;
    logic [4:0]  n_s7_dom;
    logic [11:0] r_s7_year;
    logic [3:0]  r_s7_month;
    logic [4:0]  r_s7_dom;
    logic [4:0]  r_s7_hh;
    logic [5:0]  r_s7_mi;
    logic [5:0]  r_s7_ss;

    assign w_next_year = (r_s6_mp >= 4'd10);
    assign n_s7_year   = 12'(r_s6_yoe) + (r_s6_era5 ? YEAR_ERA5 : YEAR_ERA4)
                       + 12'(w_next_year);
    assign n_s7_month  = w_next_year ? 4'(r_s6_mp - 4'd9) : 4'(r_s6_mp + 4'd3);
    assign n_s7_dom    = 5'(r_s6_doy - month_start(r_s6_mp) + 9'd1);

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[7]) begin
            r_s7_year  <= n_s7_year;
            r_s7_month <= n_s7_month;
            r_s7_dom   <= n_s7_dom;
            r_s7_hh    <= r_s6_hh;
            r_s7_mi    <= r_s6_mi;
            r_s7_ss    <= r_s6_ss;
        end
    end

    assign o_s_axis_tready = w_ctrl.en[0];
    assign o_m_axis_tvalid = w_ctrl.vld[UTCD_NSTG-1];
    assign o_m_axis_tdata  = {2'b00, r_s7_ss, r_s7_mi, r_s7_hh, r_s7_dom, r_s7_month,
                              r_s7_year};

    `UTCD_ASSERT_NXT(a_accept_lands, i_s_axis_tvalid && o_s_axis_tready, w_ctrl.vld[0], "accepted transaction not held in first stage")
    `UTCD_ASSERT_IMP(a_stall_full, !o_s_axis_tready, &w_ctrl.vld, "input stalled while a stage is empty")
    `UTCD_ASSERT_IMP(a_date_range, o_m_axis_tvalid, (r_s7_month >= 4'd1) && (r_s7_month <= 4'd12) && (r_s7_dom >= 5'd1) && (r_s7_dom <= 5'd31), "month or day out of range")
    `UTCD_ASSERT_IMP(a_time_range, o_m_axis_tvalid, (r_s7_hh <= 5'd23) && (r_s7_mi <= 6'd59) && (r_s7_ss <= 6'd59), "time of day out of range")

endmodule

@@ src/utcd_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// utcd_pipe_ctrl
// Valid bits and per-stage load enables for the conversion pipeline.
// ----------------------------------------------------------------------------
module utcd_pipe_ctrl
    import utcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    output t_pipe_ctrl o_ctrl
);

    logic [UTCD_NSTG-1:0] r_vld;
    logic [UTCD_NSTG-1:0] n_vld;
    logic [UTCD_NSTG-1:0] w_en;

    // a stage loads when empty or when its content moves on
    always_comb begin
        w_en[UTCD_NSTG-1] = !r_vld[UTCD_NSTG-1] || i_out_ready;
        for (int k = UTCD_NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < UTCD_NSTG; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctrl.en  = w_en;
    assign o_ctrl.vld = r_vld;

endmodule

@@ sim/tb_unix_time_to_calendar_date_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unix_time_to_calendar_date_core
// Streams timestamps through the converter and checks every date against an
// in-bench calendar calculation. Directed values cover the field extremes,
// day and year boundaries and leap-day handling. Random values then cover the
// full 32-bit range, day edges and the first days after the epoch. Both sides
// idle at random, and one long receiver hold fills the pipeline.
// ----------------------------------------------------------------------------
module tb_unix_time_to_calendar_date_core;

    localparam int unsigned RANDOM_ITEMS = 880;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned QUIET_FROM   = 500;
    localparam int unsigned QUIET_TO     = 650;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned IDLE_PCT     = 36;

    localparam bit [31:0] SECS_DAY    = 32'd86400;
    localparam bit [31:0] SECS_HOUR   = 32'd3600;
    localparam bit [31:0] SECS_MIN    = 32'd60;
    localparam bit [31:0] SHIFT_DAYS  = 32'd719468;
    localparam bit [31:0] ERA_DAYS    = 32'd146097;
    localparam bit [31:0] ERA_DAYS_M1 = 32'd146096;
    localparam bit [31:0] CENT_M1     = 32'd36524;
    localparam bit [31:0] QUAD_M1     = 32'd1460;
    localparam bit [31:0] YEAR_DAYS   = 32'd365;
    localparam bit [31:0] MONTH_SPAN  = 32'd153;
    localparam bit [31:0] LAST_DAY    = 32'd49710;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  dom;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cal_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;

    bit [31:0]   timestamps_to_send[$];
    t_cal_date   due_dates[$];
    int unsigned accepted_count = 0;
    int unsigned checked_count = 0;
    int unsigned early_year_count = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          quiet;

    unix_time_to_calendar_date_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),          // [31:0] unix_seconds
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)    // [11:0] year, [15:12] month,
                                             // [20:16] day_of_month, [25:21] hour,
                                             // [31:26] minute, [37:32] second
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_cal_date civil_date_of(input bit [31:0] t);
        bit [31:0] days, sod, shifted, era, doe, yoe, yr, doy, mp, dom, mon;
        t_cal_date d;
        days    = t / SECS_DAY;
        sod     = t % SECS_DAY;
        shifted = days + SHIFT_DAYS;
        era     = shifted / ERA_DAYS;
        doe     = shifted - era * ERA_DAYS;
        yoe     = (doe - doe / QUAD_M1 + doe / CENT_M1 - doe / ERA_DAYS_M1) / YEAR_DAYS;
        yr      = yoe + era * 32'd400;
        doy     = doe - (YEAR_DAYS * yoe + yoe / 32'd4 - yoe / 32'd100);
        mp      = (32'd5 * doy + 32'd2) / MONTH_SPAN;
        dom     = doy - (MONTH_SPAN * mp + 32'd2) / 32'd5 + 32'd1;
        // January and February close the March-based year
        mon     = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
        if (mon <= 32'd2)
            yr = yr + 32'd1;
        d.year   = yr[11:0];
        d.month  = mon[3:0];
        d.dom    = dom[4:0];
        d.hour   = 5'(sod / SECS_HOUR);
        d.minute = 6'((sod % SECS_HOUR) / SECS_MIN);
        d.second = 6'(sod % SECS_MIN);
        return d;
    endfunction

    function automatic t_cal_date unpack_date(input logic [39:0] v);
        t_cal_date d;
        d.year   = v[11:0];
        d.month  = v[15:12];
        d.dom    = v[20:16];
        d.hour   = v[25:21];
        d.minute = v[31:26];
        d.second = v[37:32];
        return d;
    endfunction

    function automatic bit [31:0] random_timestamp();
        bit [31:0] day;
        bit [63:0] t;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return $urandom;
        if (pick < 85) begin
            // land on either side of a midnight
            day = $urandom_range(LAST_DAY);
            t = 64'(day) * 64'(SECS_DAY) + ($urandom_range(1) ? 64'd0 : 64'd86399);
            if ($urandom_range(1))
                t = t + 64'($urandom_range(2)) - 64'd1;
            return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        end
        if (pick < 93)
            return $urandom_range(32'd200000);
        return 32'hFFFF_FFFF - $urandom_range(32'd200000);
    endfunction

    assign quiet = (accepted_count >= QUIET_FROM) && (accepted_count < QUIET_TO);

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                due_dates.push_back(civil_date_of(s_tdata));
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (timestamps_to_send.size() != 0 &&
                    (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tdata  <= timestamps_to_send.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cal_date got, want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                got = unpack_date(o_m_axis_tdata);
                if (due_dates.size() == 0) begin
                    err_count <= err_count + 1;
                    if (err_count < 10)
                        $display("unexpected result %h", o_m_axis_tdata);
                end else begin
                    want = due_dates.pop_front();
                    checked_count <= checked_count + 1;
                    if (want.month <= 4'd2)
                        early_year_count <= early_year_count + 1;
                    if (got.year != want.year || got.month != want.month ||
                        got.dom != want.dom || got.hour != want.hour ||
                        got.minute != want.minute || got.second != want.second) begin
                        err_count <= err_count + 1;
                        if (err_count < 10)
                            $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                                     want.year, want.month, want.dom,
                                     want.hour, want.minute, want.second,
                                     got.year, got.month, got.dom,
                                     got.hour, got.minute, got.second);
                    end
                end
            end
            m_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_dates.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        timestamps_to_send = '{
            32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
            32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
            32'd68169600,                    // 1972-02-29
            32'd946684799, 32'd946684800,    // turn of 1999 into 2000
            32'd951782400, 32'd951868799,    // 2000-02-29, leap century
            32'd951868800,                   // 2000-03-01
            32'd4102444800,                  // 2100-01-01
            32'd4107455999, 32'd4107542400,  // 2100 has no leap day
            32'h5555_5555, 32'hAAAA_AAAA,
            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
        };
        for (n = 0; n < RANDOM_ITEMS; n++)
            timestamps_to_send.push_back(random_timestamp());

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (timestamps_to_send.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (due_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d dates (%0d in January or February) over %0d cycles,",
                 checked_count, early_year_count, cycle_count);
        $display("with random idling on both sides and a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (err_count == 0 && due_dates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors", err_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
